// ===== hw/rtl/asp_pkg.sv =====
package asp_pkg;

  localparam int MAX_STEPS = 16;
  localparam int HOLD_BITS = 8;

  localparam int IDX_W     = 4;
  localparam int CNT_W     = $clog2(MAX_STEPS + 1);
  localparam int HOLD_IN_W = 8;
  localparam int TIME_W    = 32;
  localparam int FPS_W     = 16;
  localparam int FRAC_SH   = 24;
  localparam int PROD_W    = TIME_W - 1 + FPS_W;
  localparam int RAW_W     = PROD_W - FRAC_SH;
  localparam int TOTAL_W   = HOLD_BITS + $clog2(MAX_STEPS);
  localparam int PER_W     = TOTAL_W + 1;
  localparam int DIV_CNT_W = $clog2(RAW_W + 1);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int STEPC_W   = 5;
  localparam int MODE_W    = 2;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLAY_MODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FPS_Q8     = 2'd2;

  localparam logic [MODE_W-1:0] MODE_ONCE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOOP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PING = 2'd2;

  typedef struct packed {
    logic             start;
    logic [RAW_W-1:0] dividend;
    logic [PER_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [PER_W-1:0] remainder;
  } mod_rsp_t;

endpackage

// ===== hw/rtl/asp_hold_ram.sv =====
module asp_hold_ram (
  input  logic                           clk,
  input  logic                           we,
  input  logic [asp_pkg::IDX_W-1:0]      waddr,
  input  logic [asp_pkg::HOLD_BITS-1:0]  wdata,
  input  logic [asp_pkg::IDX_W-1:0]      raddr,
  output logic [asp_pkg::HOLD_BITS-1:0]  rdata
);

  logic [asp_pkg::HOLD_BITS-1:0] mem [asp_pkg::MAX_STEPS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/asp_mod_unit.sv =====
module asp_mod_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  asp_pkg::mod_req_t req,
  output asp_pkg::mod_rsp_t rsp
);

  logic                            busy_r;
  logic                            done_r;
  logic [asp_pkg::DIV_CNT_W-1:0]   cnt_r;
  logic [asp_pkg::RAW_W-1:0]       dvd_r;
  logic [asp_pkg::PER_W-1:0]       rem_r;
  logic [asp_pkg::PER_W-1:0]       div_r;
  logic [asp_pkg::PER_W:0]         shifted;
  logic [asp_pkg::PER_W:0]         diff;

  assign shifted = {rem_r, dvd_r[asp_pkg::RAW_W-1]};
  assign diff    = shifted - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= asp_pkg::DIV_CNT_W'(asp_pkg::RAW_W);
        dvd_r  <= req.dividend;
        div_r  <= req.divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        dvd_r <= {dvd_r[asp_pkg::RAW_W-2:0], 1'b0};
        if (shifted >= {1'b0, div_r}) begin
          rem_r <= diff[asp_pkg::PER_W-1:0];
        end else begin
          rem_r <= shifted[asp_pkg::PER_W-1:0];
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == asp_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done_r;
  assign rsp.remainder = rem_r;

endmodule

// ===== hw/rtl/animation_step_sampler.sv =====
// Channel | Direction | Handshake         | Payload
// in      | input     | in_valid/in_stall | operation, time_q16, entry_index, hold_ticks
// out     | output    | out_valid/out_stall | step_index, finished
// cfg     | input     | cfg_we            | cfg_index, cfg_wdata
//
// A write item leaves the input free for the next item. A loop or ping-pong sample makes two
// passes over the hold memory, one entry a cycle on its single read port, and uses a radix-2
// remainder unit that retires one of 23 tick bits per cycle. Play once and undefined mode 3
// skip that unit. Zero steps or zero fps skip both passes; a zero total skips the second.
// Reset is synchronous, active low; the hold memory is not cleared.
// out_stall holds a result in the output register while the next item is accepted and worked on.
module animation_step_sampler (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_operation,
  input  logic signed [asp_pkg::TIME_W-1:0] in_time_q16,
  input  logic [asp_pkg::IDX_W-1:0]         in_entry_index,
  input  logic [asp_pkg::HOLD_IN_W-1:0]     in_hold_ticks,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [asp_pkg::IDX_W-1:0]         out_step_index,
  output logic                              out_finished,
  input  logic                              cfg_we,
  input  logic [asp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [asp_pkg::CFG_DAT_W-1:0]     cfg_wdata
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SUM, ST_FOLD, ST_DIV, ST_SCAN, ST_DONE
  } state_t;

  state_t                                state_r;
  logic [asp_pkg::STEPC_W-1:0]           step_count_r;
  logic [asp_pkg::MODE_W-1:0]            play_mode_r;
  logic [asp_pkg::FPS_W-1:0]             fps_q8_r;

  logic [asp_pkg::TIME_W-2:0]            time_r;
  logic [asp_pkg::PROD_W-1:0]            prod_r;
  logic [asp_pkg::CNT_W-1:0]             n_r;
  logic [asp_pkg::CNT_W-1:0]             cnt_r;
  logic                                  rd_vld_r;
  logic [asp_pkg::IDX_W-1:0]             rd_idx_r;
  logic [asp_pkg::TOTAL_W-1:0]           total_r;
  logic [asp_pkg::TOTAL_W-1:0]           acc_r;
  logic [asp_pkg::TOTAL_W-1:0]           tick_r;
  logic                                  found_r;
  logic [asp_pkg::IDX_W-1:0]             step_r;
  logic                                  fin_r;
  logic                                  out_valid_r;
  logic [asp_pkg::IDX_W-1:0]             out_step_r;
  logic                                  out_fin_r;

  logic                                  in_xfer;
  logic                                  rd_en;
  logic [asp_pkg::HOLD_BITS-1:0]         rd_data;
  logic [asp_pkg::TOTAL_W-1:0]           hold_ext;
  logic [asp_pkg::TOTAL_W-1:0]           acc_nxt;
  logic [asp_pkg::RAW_W-1:0]             raw;
  logic [asp_pkg::PER_W-1:0]             period;
  logic [asp_pkg::PER_W-1:0]             total_ext;
  logic [asp_pkg::PER_W-1:0]             ping_back;
  logic [asp_pkg::CNT_W-1:0]             n_sat;
  logic                                  out_free;
  asp_pkg::mod_req_t                     mod_req;
  asp_pkg::mod_rsp_t                     mod_rsp;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign rd_en     = ((state_r == ST_SUM) || (state_r == ST_SCAN)) && (cnt_r < n_r);
  assign hold_ext  = asp_pkg::TOTAL_W'(rd_data);
  assign acc_nxt   = acc_r + hold_ext;
  assign raw       = prod_r[asp_pkg::PROD_W-1:asp_pkg::FRAC_SH];
  assign total_ext = {1'b0, total_r};
  assign period    = (total_r > asp_pkg::TOTAL_W'(1)) ?
                     ({total_r, 1'b0} - asp_pkg::PER_W'(2)) : asp_pkg::PER_W'(1);
  assign ping_back = period - mod_rsp.remainder;
  assign n_sat     = (step_count_r > asp_pkg::STEPC_W'(asp_pkg::MAX_STEPS)) ?
                     asp_pkg::CNT_W'(asp_pkg::MAX_STEPS) :
                     asp_pkg::CNT_W'(step_count_r);
  assign out_free  = !out_valid_r || !out_stall;

  assign mod_req.start    = (state_r == ST_FOLD) && (total_r != '0) &&
                            ((play_mode_r == asp_pkg::MODE_LOOP) ||
                             (play_mode_r == asp_pkg::MODE_PING));
  assign mod_req.dividend = raw;
  assign mod_req.divisor  = (play_mode_r == asp_pkg::MODE_PING) ? period : total_ext;

  asp_hold_ram u_ram (
    .clk   (clk),
    .we    (in_xfer && (in_operation == asp_pkg::OP_WRITE)),
    .waddr (in_entry_index),
    .wdata (in_hold_ticks[asp_pkg::HOLD_BITS-1:0]),
    .raddr (cnt_r[asp_pkg::IDX_W-1:0]),
    .rdata (rd_data)
  );

  asp_mod_unit u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_count_r <= '0;
      play_mode_r  <= '0;
      fps_q8_r     <= '0;
      rd_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          asp_pkg::REG_STEP_COUNT: step_count_r <= cfg_wdata[asp_pkg::STEPC_W-1:0];
          asp_pkg::REG_PLAY_MODE:  play_mode_r  <= cfg_wdata[asp_pkg::MODE_W-1:0];
          asp_pkg::REG_FPS_Q8:     fps_q8_r     <= cfg_wdata[asp_pkg::FPS_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      rd_vld_r <= rd_en;
      rd_idx_r <= cnt_r[asp_pkg::IDX_W-1:0];
      if (rd_en) begin
        cnt_r <= cnt_r + 1'b1;
      end
      prod_r <= time_r * fps_q8_r;

      case (state_r)
        ST_IDLE: begin
          if (in_xfer && (in_operation == asp_pkg::OP_SAMPLE)) begin
            time_r  <= in_time_q16[asp_pkg::TIME_W-1] ? '0 :
                       in_time_q16[asp_pkg::TIME_W-2:0];
            n_r     <= n_sat;
            cnt_r   <= '0;
            total_r <= '0;
            if ((n_sat == '0) || (fps_q8_r == '0)) begin
              step_r  <= '0;
              fin_r   <= 1'b1;
              state_r <= ST_DONE;
            end else begin
              state_r <= ST_SUM;
            end
          end
        end
        ST_SUM: begin
          if (rd_vld_r) begin
            total_r <= total_r + hold_ext;
          end
          if (!rd_en && !rd_vld_r) begin
            state_r <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          cnt_r   <= '0;
          acc_r   <= '0;
          found_r <= 1'b0;
          fin_r   <= 1'b0;
          step_r  <= asp_pkg::IDX_W'(n_r - 1'b1);
          if (total_r == '0) begin
            step_r  <= '0;
            fin_r   <= 1'b1;
            state_r <= ST_DONE;
          end else if (mod_req.start) begin
            state_r <= ST_DIV;
          end else begin
            if (raw >= asp_pkg::RAW_W'(total_r)) begin
              tick_r <= total_r - 1'b1;
              fin_r  <= 1'b1;
            end else begin
              tick_r <= raw[asp_pkg::TOTAL_W-1:0];
            end
            state_r <= ST_SCAN;
          end
        end
        ST_DIV: begin
          if (mod_rsp.done) begin
            if ((play_mode_r == asp_pkg::MODE_PING) && (mod_rsp.remainder >= total_ext)) begin
              tick_r <= ping_back[asp_pkg::TOTAL_W-1:0];
            end else begin
              tick_r <= mod_rsp.remainder[asp_pkg::TOTAL_W-1:0];
            end
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_vld_r) begin
            acc_r <= acc_nxt;
            if (!found_r && (tick_r < acc_nxt)) begin
              found_r <= 1'b1;
              step_r  <= rd_idx_r;
            end
          end
          if (!rd_en && !rd_vld_r) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_step_r  <= step_r;
            out_fin_r   <= fin_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_step_index = out_step_r;
  assign out_finished   = out_fin_r;

endmodule

// ===== hw/rtl/asp_checker.sv =====
module asp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_operation,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] out_step_index,
  input logic       out_finished
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_step_index) && $stable(out_finished))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown after reset");

  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_operation == asp_pkg::OP_SAMPLE) |=> in_stall)
    else $error("sample transfer did not occupy the block");

  a_write_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_operation == asp_pkg::OP_WRITE) |=> !in_stall)
    else $error("write transfer stalled the input");

endmodule

bind animation_step_sampler asp_checker u_asp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_operation   (in_operation),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_step_index (out_step_index),
  .out_finished   (out_finished)
);

// ===== bench/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [asp_pkg::MODE_W-1:0] MODE_UNDEF = 2'd3;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_OFF_CYCLES = 400;

  typedef struct packed {
    logic                              operation;
    logic signed [asp_pkg::TIME_W-1:0] time_q16;
    logic [asp_pkg::IDX_W-1:0]         entry_index;
    logic [asp_pkg::HOLD_IN_W-1:0]     hold_ticks;
  } anim_item_t;

  typedef struct packed {
    logic [asp_pkg::IDX_W-1:0] step_index;
    logic                      finished;
  } frame_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic                              in_operation = asp_pkg::OP_SAMPLE;
  logic signed [asp_pkg::TIME_W-1:0] in_time_q16 = '0;
  logic [asp_pkg::IDX_W-1:0]         in_entry_index = '0;
  logic [asp_pkg::HOLD_IN_W-1:0]     in_hold_ticks = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic [asp_pkg::IDX_W-1:0]         out_step_index;
  logic                              out_finished;
  logic                              cfg_we = 1'b0;
  logic [asp_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
  logic [asp_pkg::CFG_DAT_W-1:0]     cfg_wdata = '0;

  // shadow of the block's settings and hold table
  logic [asp_pkg::STEPC_W-1:0]   cfg_steps = '0;
  logic [asp_pkg::MODE_W-1:0]    cfg_mode = asp_pkg::MODE_ONCE;
  logic [asp_pkg::FPS_W-1:0]     cfg_fps = '0;
  logic [asp_pkg::HOLD_IN_W-1:0] hold_mem [asp_pkg::MAX_STEPS];

  frame_t pending_frames[$];
  frame_t want;
  int unsigned mismatches = 0;
  int unsigned send_gap_pct = 30;
  int unsigned recv_stall_pct = 30;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;

  animation_step_sampler u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_time_q16    (in_time_q16),
    .in_entry_index (in_entry_index),
    .in_hold_ticks  (in_hold_ticks),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_step_index (out_step_index),
    .out_finished   (out_finished),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #6 clk = ~clk;

  initial begin
    #10_000_000;
    $display("tb: errors");
    $finish;
  end

  function automatic int unsigned clip_len();
    return (cfg_steps > asp_pkg::MAX_STEPS) ? asp_pkg::MAX_STEPS : cfg_steps;
  endfunction

  function automatic int unsigned clip_total();
    int unsigned sum;
    int unsigned i;
    sum = 0;
    for (i = 0; i < clip_len(); i++) sum += hold_mem[i];
    return sum;
  endfunction

  function automatic frame_t frame_at(input logic signed [asp_pkg::TIME_W-1:0] t);
    frame_t f;
    int unsigned n, total, raw, tick, period, pos, acc, i;
    logic [63:0] prod;
    n = clip_len();
    total = clip_total();
    f.step_index = '0;
    f.finished = 1'b1;
    if (n == 0 || total == 0 || cfg_fps == 0) return f;
    prod = t[asp_pkg::TIME_W-1] ? 64'd0 : {32'd0, t} * {48'd0, cfg_fps};
    raw = 32'(prod >> asp_pkg::FRAC_SH);
    f.finished = 1'b0;
    case (cfg_mode)
      asp_pkg::MODE_LOOP: tick = raw % total;
      asp_pkg::MODE_PING: begin
        period = (total > 1) ? 2 * total - 2 : 1;
        pos = raw % period;
        tick = (pos < total) ? pos : period - pos;
      end
      default: begin
        tick = (raw >= total) ? total - 1 : raw;
        f.finished = (raw >= total);
      end
    endcase
    f.step_index = asp_pkg::IDX_W'(n - 1);
    acc = 0;
    for (i = 0; i < n; i++) begin
      acc += hold_mem[i];
      if (tick < acc) begin
        f.step_index = asp_pkg::IDX_W'(i);
        break;
      end
    end
    return f;
  endfunction

  function automatic logic signed [asp_pkg::TIME_W-1:0] pick_time();
    logic [63:0] t;
    if (cfg_fps == 0 || $urandom_range(0, 3) == 0) return $urandom;
    t = (64'($urandom_range(0, 3 * clip_total() + 2)) << asp_pkg::FRAC_SH) / cfg_fps
        + 64'($urandom_range(0, (32'd1 << asp_pkg::FRAC_SH) / cfg_fps));
    return {1'b0, t[asp_pkg::TIME_W-2:0]};
  endfunction

  function automatic logic [asp_pkg::HOLD_IN_W-1:0] pick_hold();
    case ($urandom_range(0, 7))
      0: return '0;
      1, 2, 3: return asp_pkg::HOLD_IN_W'($urandom_range(1, 4));
      default: return asp_pkg::HOLD_IN_W'($urandom_range(0, 255));
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < recv_stall_pct) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 18);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_frames.size() == 0) begin
        $error("unexpected result: step_index %0d finished %0b", out_step_index, out_finished);
        mismatches++;
      end else begin
        want = pending_frames.pop_front();
        if (out_step_index !== want.step_index) begin
          $error("step_index: expected %0d, got %0d", want.step_index, out_step_index);
          mismatches++;
        end
        if (out_finished !== want.finished) begin
          $error("finished: expected %0b, got %0b", want.finished, out_finished);
          mismatches++;
        end
      end
    end
  end

  task automatic push_item(input anim_item_t it);
    if ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= it.operation;
    in_time_q16 <= it.time_q16;
    in_entry_index <= it.entry_index;
    in_hold_ticks <= it.hold_ticks;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (it.operation == asp_pkg::OP_WRITE) hold_mem[it.entry_index] = it.hold_ticks;
    else pending_frames.push_back(frame_at(it.time_q16));
  endtask

  task automatic sample_at(input logic signed [asp_pkg::TIME_W-1:0] t);
    push_item('{asp_pkg::OP_SAMPLE, t, asp_pkg::IDX_W'($urandom),
                asp_pkg::HOLD_IN_W'($urandom)});
  endtask

  task automatic load_hold(input logic [asp_pkg::IDX_W-1:0] idx,
                           input logic [asp_pkg::HOLD_IN_W-1:0] h);
    push_item('{asp_pkg::OP_WRITE, asp_pkg::TIME_W'($urandom), idx, h});
  endtask

  // drop valid, wait out every pending result and any trailing table write
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_clip(input logic [asp_pkg::CFG_DAT_W-1:0] steps_w,
                          input logic [asp_pkg::CFG_DAT_W-1:0] mode_w,
                          input logic [asp_pkg::CFG_DAT_W-1:0] fps_w);
    settle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= asp_pkg::REG_STEP_COUNT;
    cfg_wdata <= steps_w;
    @(posedge clk);
    cfg_index <= asp_pkg::REG_PLAY_MODE;
    cfg_wdata <= mode_w;
    @(posedge clk);
    cfg_index <= asp_pkg::REG_FPS_Q8;
    cfg_wdata <= fps_w;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_steps = steps_w[asp_pkg::STEPC_W-1:0];
    cfg_mode = mode_w[asp_pkg::MODE_W-1:0];
    cfg_fps = fps_w[asp_pkg::FPS_W-1:0];
  endtask

  task automatic run_mix(input int unsigned count);
    int unsigned k;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(0, 4) == 0) load_hold(asp_pkg::IDX_W'($urandom), pick_hold());
      else sample_at(pick_time());
    end
  endtask

  task automatic random_clip();
    logic [asp_pkg::CFG_DAT_W-1:0] steps_w, mode_w, fps_w;
    case ($urandom_range(0, 9))
      0: steps_w = '0;
      1: steps_w = asp_pkg::CFG_DAT_W'($urandom_range(17, 31));
      2: steps_w = asp_pkg::CFG_DAT_W'(asp_pkg::MAX_STEPS);
      3, 4, 5: steps_w = asp_pkg::CFG_DAT_W'($urandom_range(1, 4));
      default: steps_w = asp_pkg::CFG_DAT_W'($urandom_range(1, 16));
    endcase
    mode_w = ($urandom_range(0, 9) == 0) ? asp_pkg::CFG_DAT_W'(MODE_UNDEF) :
             asp_pkg::CFG_DAT_W'($urandom_range(0, 2));
    if ($urandom_range(0, 3) == 0) begin
      steps_w = steps_w | (asp_pkg::CFG_DAT_W'($urandom) << asp_pkg::STEPC_W);
      mode_w = mode_w | (asp_pkg::CFG_DAT_W'($urandom) << asp_pkg::MODE_W);
    end
    case ($urandom_range(0, 7))
      0: fps_w = '0;
      1: fps_w = 16'hFFFF;
      2: fps_w = asp_pkg::CFG_DAT_W'($urandom_range(1, 16));
      3: fps_w = 16'h0100;
      default: fps_w = asp_pkg::CFG_DAT_W'($urandom_range(1, 65535));
    endcase
    set_clip(steps_w, mode_w, fps_w);
  endtask

  task automatic test_table_load();
    load_hold(4'd0, 8'd0);
    load_hold(4'd1, 8'd0);
    load_hold(4'd2, 8'd255);
    load_hold(4'd3, 8'd1);
    load_hold(4'd4, 8'd7);
  endtask

  task automatic test_empty_clip();
    set_clip(16'd0, asp_pkg::CFG_DAT_W'(asp_pkg::MODE_ONCE), 16'h0100);
    sample_at(32'h0005_0000);
    set_clip(16'd2, asp_pkg::CFG_DAT_W'(asp_pkg::MODE_LOOP), 16'h0100);
    sample_at(32'h0001_0000);
    set_clip(16'd5, asp_pkg::CFG_DAT_W'(asp_pkg::MODE_LOOP), 16'd0);
    sample_at(32'h0001_0000);
  endtask

  task automatic test_play_once();
    set_clip(16'd5, asp_pkg::CFG_DAT_W'(asp_pkg::MODE_ONCE), 16'h0100);
    sample_at(32'h8000_0000);
    sample_at(32'h7FFF_FFFF);
    sample_at(32'h00FF_0000);
    sample_at(32'h0106_8000);
  endtask

  task automatic test_loop();
    set_clip(16'd5, asp_pkg::CFG_DAT_W'(asp_pkg::MODE_LOOP), 16'hFFFF);
    sample_at(32'h7FFF_FFFF);
    sample_at(32'hFFFF_FFFF);
  endtask

  task automatic test_ping_pong();
    set_clip(16'd5, asp_pkg::CFG_DAT_W'(asp_pkg::MODE_PING), 16'h0100);
    sample_at(32'h012C_0000);
    sample_at(32'h0258_0000);
    load_hold(4'd0, 8'd1);
    set_clip(16'd2, asp_pkg::CFG_DAT_W'(asp_pkg::MODE_PING), 16'h0100);
    sample_at(32'h0003_0000);
  endtask

  task automatic test_undefined_mode();
    set_clip(16'd5, asp_pkg::CFG_DAT_W'(MODE_UNDEF), 16'h0100);
    sample_at(32'h03E8_0000);
  endtask

  task automatic test_random();
    int unsigned p, k;
    for (k = 0; k < asp_pkg::MAX_STEPS; k++) load_hold(asp_pkg::IDX_W'(k), pick_hold());
    for (p = 0; p < 34; p++) begin
      case ($urandom_range(0, 2))
        0: send_gap_pct = 0;
        1: send_gap_pct = 20;
        default: send_gap_pct = 50;
      endcase
      case ($urandom_range(0, 2))
        0: recv_stall_pct = 0;
        1: recv_stall_pct = 10;
        default: recv_stall_pct = 40;
      endcase
      random_clip();
      run_mix(48);
    end
  endtask

  task automatic test_backpressure();
    int unsigned k;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    set_clip(asp_pkg::CFG_DAT_W'(asp_pkg::MAX_STEPS), asp_pkg::CFG_DAT_W'(asp_pkg::MODE_LOOP),
             16'hFFFF);
    hold_left <= HOLD_OFF_CYCLES;
    for (k = 0; k < 20; k++) sample_at(pick_time());
  endtask

  task automatic test_quiet_tail();
    send_gap_pct = 0;
    recv_stall_pct = 0;
    random_clip();
    run_mix(80);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_table_load();
    test_empty_clip();
    test_play_once();
    test_loop();
    test_ping_pong();
    test_undefined_mode();
    test_random();
    test_backpressure();
    test_quiet_tail();
    settle();
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/asp_pkg.sv
hw/rtl/asp_hold_ram.sv
hw/rtl/asp_mod_unit.sv
hw/rtl/animation_step_sampler.sv
hw/rtl/asp_checker.sv
bench/tb.sv
